FILE: rtl/sstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int TRACK_W          = 16;
  localparam int SEEK_W           = 21;
  localparam int MAX_REQUESTS_DEF = 32;
  localparam int TRACK_BITS_DEF   = 16;

  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SERVE
  } state_t;

  // candidate vs. current best, from the shared compare unit
  typedef struct packed {
    logic               take;
    logic [TRACK_W-1:0] span;
  } cmp_res_t;

  // one result beat
  typedef struct packed {
    logic [TRACK_W-1:0] trk;
    logic [SEEK_W-1:0]  sum;
    logic               moved;
    logic               dropped;
    logic               last;
  } result_t;

endpackage

FILE: rtl/sstf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_store
// Request track memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sstf_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/sstf_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_cmp
// Shared distance and compare unit: |cand - head| against the current best.
// ----------------------------------------------------------------------------
module sstf_cmp import sstf_pkg::*; (
  input  logic [TRACK_W-1:0] cand,
  input  logic [TRACK_W-1:0] head,
  input  logic               have_best,
  input  logic [TRACK_W-1:0] best_d,
  input  logic [TRACK_W-1:0] best_t,
  output cmp_res_t           res
);

  logic [TRACK_W-1:0] d;

  always_comb begin
    d = (cand > head) ? (cand - head) : (head - cand);
    res.span = d;
    // nearer wins; equal distance goes to the higher track; full tie keeps
    // the earlier entry
    res.take = !have_best || (d < best_d) || ((d == best_d) && (cand > best_t));
  end

endmodule

FILE: rtl/sstf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_seq
// Sequencer: request bookkeeping, store scan, best tracking and result beats.
// ----------------------------------------------------------------------------
module sstf_seq import sstf_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
  parameter int TW           = TRACK_W,
  parameter int CW           = 6,
  parameter int IW           = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               mode,
  input  logic [TW-1:0]      trk_in,
  output logic               busy,
  // store ports
  output logic               wr_en,
  output logic [IW-1:0]      wr_addr,
  output logic               rd_en,
  output logic [IW-1:0]      rd_addr,
  input  logic [TW-1:0]      rd_data,
  // compare unit
  output logic [TRACK_W-1:0] cmp_cand,
  output logic [TRACK_W-1:0] cmp_head,
  output logic               cmp_have,
  output logic [TRACK_W-1:0] cmp_best_d,
  output logic [TRACK_W-1:0] cmp_best_t,
  input  cmp_res_t           cmp_res,
  // results
  output logic               res_vld,
  output result_t            res
);

  state_t state, state_next;

  logic [CW-1:0]           count;
  logic [MAX_REQUESTS-1:0] pending;
  logic [TW-1:0]           head;
  logic [SEEK_W-1:0]       sum;
  logic                    ovf;
  logic [CW-1:0]           issue;
  logic                    rd_vld;
  logic [IW-1:0]           rd_idx;
  logic                    have_best;
  logic [IW-1:0]           best_idx;
  logic [TRACK_W-1:0]      best_d;
  logic [TW-1:0]           best_t;

  logic                    accept;
  logic                    issue_go;
  logic                    full;
  logic [MAX_REQUESTS-1:0] clr_mask;
  logic                    last_serve;
  logic [SEEK_W:0]         sum_add;
  logic [SEEK_W-1:0]       sum_sat;

  always_comb begin
    accept     = start && (state == ST_IDLE);
    issue_go   = (state == ST_SCAN) && (issue < count);
    full       = (count >= CW'(MAX_REQUESTS));
    clr_mask   = MAX_REQUESTS'(1) << best_idx;
    last_serve = ((pending & ~clr_mask) == '0);
    sum_add    = {1'b0, sum} + (SEEK_W+1)'(best_d);
    sum_sat    = (sum_add > (SEEK_W+1)'(SEEK_MAX)) ? SEEK_MAX : sum_add[SEEK_W-1:0];

    busy       = (state != ST_IDLE);
    wr_en      = accept && (mode == MODE_LOAD) && !full;
    wr_addr    = count[IW-1:0];
    rd_en      = issue_go;
    rd_addr    = issue[IW-1:0];

    cmp_cand   = TRACK_W'(rd_data);
    cmp_head   = TRACK_W'(head);
    cmp_have   = have_best;
    cmp_best_d = best_d;
    cmp_best_t = TRACK_W'(best_t);

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_START) && (pending != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_go && !rd_vld) begin
          state_next = ST_SERVE;
        end
      end
      ST_SERVE: begin
        state_next = last_serve ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= '0;
      head      <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      rd_vld    <= 1'b0;
      have_best <= 1'b0;
      res_vld   <= 1'b0;
    end else begin
      // beat on an empty start or on each serve step
      res_vld <= (accept && (mode == MODE_START) && (pending == '0)) ||
                 (state == ST_SERVE);
      rd_vld  <= issue_go && pending[issue[IW-1:0]];
      rd_idx  <= issue[IW-1:0];
      unique case (state)
        ST_IDLE: begin
          issue     <= '0;
          have_best <= 1'b0;
          if (accept && (mode == MODE_LOAD)) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              pending[count[IW-1:0]] <= 1'b1;
              count                  <= count + CW'(1);
            end
          end else if (accept) begin
            head <= trk_in;
            sum  <= '0;
            if (pending == '0) begin
              // empty run: a single no-move beat
              res     <= '{trk: TRACK_W'(trk_in), sum: '0, moved: 1'b0,
                           dropped: ovf, last: 1'b1};
              count   <= '0;
              ovf     <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (issue_go) begin
            issue <= issue + CW'(1);
          end
          if (rd_vld && cmp_res.take) begin
            have_best <= 1'b1;
            best_idx  <= rd_idx;
            best_d    <= cmp_res.span;
            best_t    <= rd_data;
          end
        end
        ST_SERVE: begin
          head      <= best_t;
          sum       <= sum_sat;
          // clears to empty on the last serve
          pending   <= pending & ~clr_mask;
          res       <= '{trk: TRACK_W'(best_t), sum: sum_sat, moved: 1'b1,
                         dropped: ovf, last: last_serve};
          issue     <= '0;
          have_best <= 1'b0;
          if (last_serve) begin
            count   <= '0;
            ovf     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sstf_disk_request_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_top
// Shortest-seek-first disk request scheduler with a single shared comparator.
// ----------------------------------------------------------------------------
// Usage: a beat is taken at a rising edge with start high and busy low.
// mode = 0 loads one request track (busy stays low); loads past
// MAX_REQUESTS are dropped and flagged in "dropped" of the coming run.
// mode = 1 starts a run from head position "track". For each served
// request the sequencer walks all N store entries, N being the loaded
// request count of the batch, through the one memory read port and the
// shared distance/compare unit, compares the last registered read, lets
// the read-valid flag drop, then serves the winner in a serve step.
// Results leave as one-cycle strobe beats, each in the cycle after its serve
// step; the receiver cannot stall, so it must take every beat in the cycle
// it is shown. A start with nothing pending gives one beat with moved = 0
// and last = 1. Tracks are masked to TRACK_BITS; the seek total saturates
// at its field maximum.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_top import sstf_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = TRACK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 mode,
  input  logic [TRACK_W-1:0]   track,
  output logic                 busy,
  output logic                 strobe,
  output logic [TRACK_W-1:0]   served_track,
  output logic [SEEK_W-1:0]    total_seek,
  output logic                 moved,
  output logic                 dropped,
  output logic                 last
);

  // stored track width, count width (holds MAX_REQUESTS) and index width
  localparam int TW = (TRACK_BITS < TRACK_W) ? TRACK_BITS : TRACK_W;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [TW-1:0]      rd_data;
  logic [TW-1:0]      trk_in;
  logic [TRACK_W-1:0] cmp_cand;
  logic [TRACK_W-1:0] cmp_head;
  logic               cmp_have;
  logic [TRACK_W-1:0] cmp_best_d;
  logic [TRACK_W-1:0] cmp_best_t;
  cmp_res_t           cmp_res;
  result_t            res;

  assign trk_in = track[TW-1:0];

  sstf_store #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (TW),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (trk_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sstf_cmp u_cmp (
    .cand      (cmp_cand),
    .head      (cmp_head),
    .have_best (cmp_have),
    .best_d    (cmp_best_d),
    .best_t    (cmp_best_t),
    .res       (cmp_res)
  );

  sstf_seq #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TW           (TW),
    .CW           (CW),
    .IW           (IW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .trk_in     (trk_in),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .cmp_cand   (cmp_cand),
    .cmp_head   (cmp_head),
    .cmp_have   (cmp_have),
    .cmp_best_d (cmp_best_d),
    .cmp_best_t (cmp_best_t),
    .cmp_res    (cmp_res),
    .res_vld    (strobe),
    .res        (res)
  );

  // result beat fields straight from the output register
  assign served_track = res.trk;
  assign total_seek   = res.sum;
  assign moved        = res.moved;
  assign dropped      = res.dropped;
  assign last         = res.last;

endmodule

FILE: rtl/sstf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks on scheduler result beats, bound to the top level.
// ----------------------------------------------------------------------------
module sstf_checker import sstf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               mode,
  input logic [TRACK_W-1:0] track,
  input logic               busy,
  input logic               strobe,
  input logic [TRACK_W-1:0] served_track,
  input logic [SEEK_W-1:0]  total_seek,
  input logic               moved,
  input logic               dropped,
  input logic               last
);

  // a no-move beat is the whole run and carries no seek
  a_nomove_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !moved |-> last && (total_seek == '0))
    else $error("no-move beat not final or nonzero seek");

  // a run still in progress keeps the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("idle while run in progress");

  // every serve needs a scan, so beats of one run never sit back to back
  a_beat_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> !strobe)
    else $error("back-to-back result beats");

  // a load beat never causes a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == MODE_LOAD) |=> !strobe)
    else $error("result after load beat");

endmodule

bind sstf_disk_request_scheduler_top sstf_checker u_sstf_checker (.*);

FILE: tb/sstf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_tb_pkg
// Scoreboard for the SSTF scheduler: predicts the service order of every run
// and checks each result beat against it.
// ----------------------------------------------------------------------------
package sstf_tb_pkg;
  import sstf_pkg::*;

  localparam logic [TRACK_W-1:0] TRK_MASK = TRACK_W'((64'd1 << TRACK_BITS_DEF) - 1);

  class sstf_scoreboard;
    logic [TRACK_W-1:0]        req_track [MAX_REQUESTS_DEF];
    int unsigned               req_count;
    bit [MAX_REQUESTS_DEF-1:0] unserved;
    logic [TRACK_W-1:0]        head;
    int unsigned               seek_total;
    bit                        overflow;
    result_t                   expected_services [$];

    int errors;
    int checked;
    int loads;
    int runs;
    int empty_runs;
    int dropped_runs;

    function new();
      req_count  = 0;
      unserved   = '0;
      head       = '0;
      seek_total = 0;
      overflow   = 1'b0;
      errors     = 0;
      checked    = 0;
      loads      = 0;
      runs       = 0;
      empty_runs = 0;
      dropped_runs = 0;
    endfunction

    function int outstanding();
      return expected_services.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // greedy nearest-track order, ties to the higher track, equal tracks by index
    function void plan_run(logic [TRACK_W-1:0] start_trk);
      result_t     r;
      int          best;
      int unsigned bd;
      int unsigned d;
      logic [TRACK_W-1:0] bt;

      runs++;
      if (overflow)
        dropped_runs++;
      head       = start_trk & TRK_MASK;
      seek_total = 0;
      if (unserved == '0) begin
        empty_runs++;
        r.trk     = head;
        r.sum     = '0;
        r.moved   = 1'b0;
        r.dropped = overflow;
        r.last    = 1'b1;
        expected_services = {expected_services, r};
      end else begin
        while (unserved != '0) begin
          best = -1;
          bd   = 0;
          bt   = '0;
          for (int i = 0; i < int'(req_count); i++) begin
            if (unserved[i]) begin
              d = (req_track[i] > head) ? int'(req_track[i]) - int'(head)
                                        : int'(head) - int'(req_track[i]);
              if (best < 0 || d < bd || (d == bd && req_track[i] > bt)) begin
                best = i;
                bd   = d;
                bt   = req_track[i];
              end
            end
          end
          unserved[best] = 1'b0;
          if (seek_total + bd > int'(SEEK_MAX))
            seek_total = int'(SEEK_MAX);
          else
            seek_total += bd;
          head      = bt;
          r.trk     = bt;
          r.sum     = SEEK_W'(seek_total);
          r.moved   = 1'b1;
          r.dropped = overflow;
          r.last    = (unserved == '0);
          expected_services = {expected_services, r};
        end
      end
      req_count = 0;
      unserved  = '0;
      overflow  = 1'b0;
    endfunction

    function void note_beat(logic m, logic [TRACK_W-1:0] t);
      if (m == MODE_LOAD) begin
        loads++;
        if (req_count < MAX_REQUESTS_DEF) begin
          req_track[req_count] = t & TRK_MASK;
          unserved[req_count]  = 1'b1;
          req_count++;
        end else begin
          overflow = 1'b1;
        end
      end else begin
        plan_run(t);
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      checked++;
      if (expected_services.size() == 0) begin
        report($sformatf("unexpected beat track=%0d seek=%0d", got.trk, got.sum));
      end else begin
        want = expected_services.pop_front();
        if (got.trk !== want.trk)
          report($sformatf("served_track %0d, want %0d", got.trk, want.trk));
        if (got.sum !== want.sum)
          report($sformatf("total_seek %0d, want %0d", got.sum, want.sum));
        if (got.moved !== want.moved)
          report($sformatf("moved %b, want %b", got.moved, want.moved));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped %b, want %b", got.dropped, want.dropped));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b", got.last, want.last));
      end
    endtask
  endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sstf_disk_request_scheduler_top: loads batches of
// track requests, starts runs from chosen head tracks, and checks every
// result beat against a greedy shortest-seek prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sstf_pkg::*;
  import sstf_tb_pkg::*;

  localparam int RANDOM_ITEMS = 320;

  // how the tracks of one random batch are spread
  typedef enum int {
    SPREAD_WIDE,
    SPREAD_CLUSTER,
    SPREAD_EDGES
  } spread_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               mode;
  logic [TRACK_W-1:0] track;
  logic               busy;
  logic               strobe;
  logic [TRACK_W-1:0] served_track;
  logic [SEEK_W-1:0]  total_seek;
  logic               moved;
  logic               dropped;
  logic               last;

  sstf_scoreboard sb;
  int             random_items;

  sstf_disk_request_scheduler_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .track        (track),
    .busy         (busy),
    .strobe       (strobe),
    .served_track (served_track),
    .total_seek   (total_seek),
    .moved        (moved),
    .dropped      (dropped),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even if every beat started
  // a full 32-entry run after the longest idle gap.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: the block cannot be stalled, so every strobe beat is taken
  // at the edge that ends its cycle. Sampling at posedge sees the pre-edge
  // values since the block updates its outputs in the NBA region.
  always @(posedge clk) begin
    result_t got;
    if (!rst && strobe) begin
      got.trk     = served_track;
      got.sum     = total_seek;
      got.moved   = moved;
      got.dropped = dropped;
      got.last    = last;
      sb.check_result(got);
    end
  end

  // One command beat. Inputs move on the falling edge only. start stays high
  // across back-to-back beats (gap of zero) so it never gets two NBAs in one
  // step. The beat is taken at the first rising edge with busy low.
  task automatic send_beat(logic m, logic [TRACK_W-1:0] t, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    mode  <= m;
    track <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(m, t);
  endtask

  // Loads a batch, then starts the run. With calm set the beats follow back to
  // back, otherwise each beat first waits out a random idle gap.
  task automatic serve_batch(input logic [TRACK_W-1:0] reqs [$],
                             input logic [TRACK_W-1:0] head_trk, input bit calm);
    foreach (reqs[i])
      send_beat(MODE_LOAD, reqs[i], calm ? 0 : $urandom_range(15, 0));
    send_beat(MODE_START, head_trk, calm ? 0 : $urandom_range(15, 0));
  endtask

  function automatic logic [TRACK_W-1:0] pick_track(spread_t spread,
                                                    logic [TRACK_W-1:0] base);
    logic [TRACK_W-1:0] t;
    case (spread)
      SPREAD_CLUSTER: t = base + TRACK_W'($urandom_range(15, 0));
      SPREAD_EDGES: begin
        case ($urandom_range(3, 0))
          0:       t = '0;
          1:       t = '1;
          2:       t = base;
          default: t = TRACK_W'($urandom_range(65535, 0));
        endcase
      end
      default: t = TRACK_W'($urandom_range(65535, 0));
    endcase
    return t;
  endfunction

  initial begin
    logic [TRACK_W-1:0] reqs [$];
    logic [TRACK_W-1:0] base;
    logic [TRACK_W-1:0] head_trk;
    spread_t            spread;
    int                 n;
    int                 batch;
    bit                 calm;

    rst   = 1'b1;
    start = 1'b0;
    mode  = MODE_LOAD;
    track = '0;
    sb    = new();
    random_items = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // start with nothing pending, head at zero
    reqs = {};
    serve_batch(reqs, 16'd0, 1'b0);
    // equal distance both ways: the higher track wins
    reqs = {16'd100, 16'd300};
    serve_batch(reqs, 16'd200, 1'b0);
    // duplicates sitting at the head: zero-seek services by store order
    reqs = {16'd500, 16'd500, 16'hFFFF};
    serve_batch(reqs, 16'd500, 1'b1);
    // track extremes, head at the top track
    reqs = {16'd0, 16'hFFFF};
    serve_batch(reqs, 16'hFFFF, 1'b0);
    // track extremes, head in the middle
    reqs = {16'd0, 16'hFFFF};
    serve_batch(reqs, 16'h8000, 1'b0);
    // alternating bit patterns
    reqs = {16'h5555, 16'hAAAA};
    serve_batch(reqs, 16'h0000, 1'b1);
    // empty start at the top track
    reqs = {};
    serve_batch(reqs, 16'hFFFF, 1'b0);

    // ---- random ----
    // First batch overfills the store, second fills it exactly; after that
    // mostly short batches, with the odd empty or near-full to overfull one.
    batch = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (batch == 0)
        n = MAX_REQUESTS_DEF + 4;
      else if (batch == 1)
        n = MAX_REQUESTS_DEF;
      else begin
        case ($urandom_range(9, 0))
          0:       n = $urandom_range(MAX_REQUESTS_DEF + 4, MAX_REQUESTS_DEF - 2);
          1:       n = 0;
          default: n = $urandom_range(8, 1);
        endcase
      end
      spread = spread_t'($urandom_range(2, 0));
      base   = TRACK_W'($urandom_range(65535, 0));
      calm   = ($urandom_range(3, 0) == 0);
      reqs   = {};
      repeat (n) reqs = {reqs, pick_track(spread, base)};
      head_trk = pick_track(spread, base);
      serve_batch(reqs, head_trk, calm);
      random_items += n + 1;
      batch++;
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then leave room for a stray beat
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d loads over %0d runs (%0d empty, %0d with drops)",
             sb.loads, sb.runs, sb.empty_runs, sb.dropped_runs);
    $display("checked %0d result beats, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sstf_pkg.sv
rtl/sstf_store.sv
rtl/sstf_cmp.sv
rtl/sstf_seq.sv
rtl/sstf_disk_request_scheduler_top.sv
rtl/sstf_checker.sv
tb/sstf_tb_pkg.sv
tb/testbench.sv
